### src/olv_pkg.sv
// package for the ordered value list unit: sizes, action and status codes,
// and the command bundle passed from the controller to the datapath
// no dependencies
package olv_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int ACT_W    = 3;
  localparam int STS_W    = 2;
  localparam int OCNT_W   = 5;

  localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PREPEND  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CONTAINS = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd4;

  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } olv_state_t;

  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // apply the latched item to the cells and load the result
  } olv_cmd_t;

endpackage

### src/olv_ctrl.sv
// controller for the ordered value list unit: input/output handshake and
// the two-state sequencer driving the datapath
// depends on olv_pkg
module olv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output olv_pkg::olv_cmd_t cmd
);

  olv_pkg::olv_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  // result register can take a new beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olv_pkg::S_IDLE: begin
        if (in_valid) state_nxt = olv_pkg::S_EXEC;
      end
      olv_pkg::S_EXEC: begin
        if (out_free) state_nxt = olv_pkg::S_IDLE;
      end
      default: state_nxt = olv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      olv_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      olv_pkg::S_EXEC: begin
        cmd.exec = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olv_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### src/olv_dp.sv
// datapath for the ordered value list unit: the row of entry cells, the
// entry count, parallel match logic and the result register
// depends on olv_pkg
module olv_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  olv_pkg::olv_cmd_t                 cmd,
  input  logic        [olv_pkg::ACT_W-1:0]  in_action,
  input  logic signed [olv_pkg::VAL_W-1:0]  in_value,
  output logic        [olv_pkg::STS_W-1:0]  out_status,
  output logic                              out_found,
  output logic        [olv_pkg::OCNT_W-1:0] out_entry_count
);

  logic [olv_pkg::ACT_W-1:0]  act_r;
  logic [olv_pkg::VAL_W-1:0]  val_r;
  logic [olv_pkg::VAL_W-1:0]  entries_r   [olv_pkg::CAPACITY];
  logic [olv_pkg::VAL_W-1:0]  entries_nxt [olv_pkg::CAPACITY];
  logic [olv_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [olv_pkg::CAPACITY-1:0] hit;
  logic [olv_pkg::CAPACITY-1:0] at_or_after;
  logic                       any_hit;
  logic                       full;
  logic [olv_pkg::STS_W-1:0]  status_nxt;
  logic                       found_nxt;
  logic [olv_pkg::STS_W-1:0]  out_status_r;
  logic                       out_found_r;
  logic [olv_pkg::OCNT_W-1:0] out_count_r;

  assign full = count_r >= olv_pkg::CNT_W'(olv_pkg::CAPACITY);

  // per-cell compare, live cells only
  always_comb begin
    for (int i = 0; i < olv_pkg::CAPACITY; i++) begin
      hit[i] = (entries_r[i] == val_r) && (olv_pkg::CNT_W'(i) < count_r);
    end
  end

  // cells from the first match onwards take their successor on remove
  always_comb begin
    at_or_after[0] = hit[0];
    for (int i = 1; i < olv_pkg::CAPACITY; i++) begin
      at_or_after[i] = at_or_after[i-1] | hit[i];
    end
  end

  assign any_hit = at_or_after[olv_pkg::CAPACITY-1];

  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    status_nxt  = olv_pkg::ST_OK;
    found_nxt   = 1'b0;
    case (act_r)
      olv_pkg::ACT_APPEND: begin
        if (full) begin
          status_nxt = olv_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < olv_pkg::CAPACITY; i++) begin
            if (olv_pkg::CNT_W'(i) == count_r) entries_nxt[i] = val_r;
          end
          count_nxt = count_r + 1'b1;
        end
      end
      olv_pkg::ACT_PREPEND: begin
        if (full) begin
          status_nxt = olv_pkg::ST_FULL;
        end else begin
          entries_nxt[0] = val_r;
          for (int i = 1; i < olv_pkg::CAPACITY; i++) begin
            entries_nxt[i] = entries_r[i-1];
          end
          count_nxt = count_r + 1'b1;
        end
      end
      olv_pkg::ACT_REMOVE: begin
        if (any_hit) begin
          for (int i = 0; i < olv_pkg::CAPACITY - 1; i++) begin
            if (at_or_after[i]) entries_nxt[i] = entries_r[i+1];
          end
          count_nxt = count_r - 1'b1;
          found_nxt = 1'b1;
        end else begin
          status_nxt = olv_pkg::ST_NOT_FOUND;
        end
      end
      olv_pkg::ACT_CONTAINS: begin
        found_nxt = any_hit;
      end
      olv_pkg::ACT_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = olv_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      val_r <= in_value;
    end
    if (cmd.exec) begin
      entries_r    <= entries_nxt;
      out_status_r <= status_nxt;
      out_found_r  <= found_nxt;
      out_count_r  <= olv_pkg::OCNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_entry_count = out_count_r;

endmodule

### src/ordered_value_list_unit.sv
// channel | direction | fields                              | handshake
// in_     | into unit | in_action, in_value                  | in_valid / in_stall
// out_    | from unit | out_status, out_found, out_entry_count | out_valid / out_stall
//
// one item at a time: S_IDLE latches the beat, then S_EXEC compares
// all cells at once and shifts, inserts or drops an entry in the cell row
// the result sits in an output register; while it is stalled the unit still
// latches one more beat, then holds that item in S_EXEC until it drains
// rst_n (synchronous, active low) empties the list; cell contents are not reset
// top level of the ordered value list unit
// depends on olv_pkg, olv_ctrl, olv_dp
module ordered_value_list_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic        [olv_pkg::ACT_W-1:0]  in_action,
  input  logic signed [olv_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [olv_pkg::STS_W-1:0]  out_status,
  output logic                              out_found,
  output logic        [olv_pkg::OCNT_W-1:0] out_entry_count
);

  olv_pkg::olv_cmd_t cmd;

  olv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  olv_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_entry_count (out_entry_count)
  );

endmodule

### src/olv_checker.sv
// port-level checks for the ordered value list unit, bound to the top level
// depends on olv_pkg and ordered_value_list_unit
module olv_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic        [olv_pkg::STS_W-1:0]  out_status,
  input logic                              out_found,
  input logic        [olv_pkg::OCNT_W-1:0] out_entry_count
);

  // one item at a time: an accepted beat blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("beat accepted while previous item still in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_found)
      && $stable(out_entry_count))
    else $error("stalled result changed");

  // a refused insert only happens on a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == olv_pkg::ST_FULL |->
      !out_found && out_entry_count == olv_pkg::OCNT_W'(olv_pkg::CAPACITY))
    else $error("full status with a list that is not full");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == olv_pkg::ST_NOT_FOUND |-> !out_found)
    else $error("not-found status with found set");

endmodule

bind ordered_value_list_unit olv_checker u_olv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_entry_count (out_entry_count)
);

### tb/sv/olv_list_mirror_pkg.sv
// list mirror for the ordered value list unit testbench: keeps its own copy of
// the entries, predicts the reply for every accepted beat and checks replies in order
// depends on olv_pkg
package olv_list_mirror_pkg;
  import olv_pkg::*;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic              found;
    logic [OCNT_W-1:0] entry_count;
  } list_reply_t;

  class list_mirror;
    logic signed [VAL_W-1:0] cells [CAPACITY];
    int          held;
    list_reply_t pending_replies [$];
    int          errors;
    int          replies_seen;
    int          full_refusals;
    int          failed_removes;
    int          lookup_hits;

    function new();
      held           = 0;
      errors         = 0;
      replies_seen   = 0;
      full_refusals  = 0;
      failed_removes = 0;
      lookup_hits    = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // one of the values currently held, so lookups and removes hit
    function logic signed [VAL_W-1:0] pick_held();
      return cells[$urandom_range(held - 1)];
    endfunction

    // update the mirrored list with an accepted beat and queue its reply
    function void apply_beat(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val);
      list_reply_t reply;
      int          first;
      int          i;
      reply = '0;
      // lowest matching index, or held when there is no match
      first = held;
      for (i = held - 1; i >= 0; i--)
        if (cells[i] == val) first = i;
      case (act)
        ACT_APPEND: begin
          if (held >= CAPACITY) begin
            reply.status = ST_FULL;
            full_refusals++;
          end else begin
            cells[held] = val;
            held++;
          end
        end
        ACT_PREPEND: begin
          if (held >= CAPACITY) begin
            reply.status = ST_FULL;
            full_refusals++;
          end else begin
            for (i = held; i > 0; i--)
              cells[i] = cells[i - 1];
            cells[0] = val;
            held++;
          end
        end
        ACT_REMOVE: begin
          if (first < held) begin
            for (i = first; i + 1 < held; i++)
              cells[i] = cells[i + 1];
            held--;
            reply.found = 1'b1;
          end else begin
            reply.status = ST_NOT_FOUND;
            failed_removes++;
          end
        end
        ACT_CONTAINS: begin
          reply.found = (first < held);
          if (reply.found) lookup_hits++;
        end
        ACT_CLEAR: begin
          held = 0;
        end
        default: begin
          // spare action codes leave the list alone
        end
      endcase
      reply.entry_count = OCNT_W'(held);
      pending_replies.push_back(reply);
    endfunction

    function void check_reply(list_reply_t got);
      list_reply_t want;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, got status %0d found %0d count %0d",
                 $time, got.status, got.found, got.entry_count);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0d, got %0d", $time, want.found, got.found);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry count mismatch, expected %0d, got %0d",
                 $time, want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

endpackage

### tb/sv/tb_ordered_value_list_unit.sv
// testbench top for the ordered value list unit: directed and random list
// operations under random idling on both channels, replies checked by the list mirror
// depends on olv_pkg, olv_list_mirror_pkg, ordered_value_list_unit
module tb_ordered_value_list_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import olv_pkg::*;
  import olv_list_mirror_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_PER_PHASE = 310;
  localparam int SETTLE_CYCLES    = 8;
  // timeout cap for roughly 960 beats, even with both sides idling
  localparam int CYCLE_LIMIT      = 200_000;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = ~VAL_MIN;

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_stall;
  logic        [ACT_W-1:0]  in_action       = ACT_CLEAR;
  logic signed [VAL_W-1:0]  in_value        = '0;
  logic                     out_valid;
  logic                     out_stall       = 1'b0;
  logic        [STS_W-1:0]  out_status;
  logic                     out_found;
  logic        [OCNT_W-1:0] out_entry_count;

  list_mirror mirror;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         beats_sent    = 0;
  int         cycle_cnt     = 0;

  ordered_value_list_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_entry_count (out_entry_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver side stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      mirror.check_reply({out_status, out_found, out_entry_count});
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d replies outstanding", cycle_cnt, mirror.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // entered just after a falling edge, returns just after one
  task automatic send_beat(input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do @(posedge clk); while (in_stall);
    mirror.apply_beat(act, val);
    beats_sent++;
    @(negedge clk);
  endtask

  // hold the input back until every reply has drained
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(negedge clk); while (mirror.pending() != 0);
  endtask

  task automatic run_directed();
    int                      k;
    logic signed [VAL_W-1:0] v;
    send_beat(ACT_CLEAR, 32'sh1234_5678);
    send_beat(ACT_REMOVE, 32'sd7);
    send_beat(ACT_CONTAINS, 32'sd7);
    send_beat(ACT_APPEND, VAL_MIN);
    send_beat(ACT_PREPEND, VAL_MAX);
    // fill to capacity from both ends, with zero, all ones and a second minimum
    for (k = 2; k < CAPACITY; k++) begin
      v = (k == 9) ? VAL_MIN : VAL_W'(k - 4);
      send_beat(k[0] ? ACT_APPEND : ACT_PREPEND, v);
    end
    send_beat(ACT_APPEND, 32'sd99);
    send_beat(ACT_PREPEND, VAL_MIN);
    send_beat(ACT_CONTAINS, VAL_MAX);
    // only the first of the two minimum entries goes
    send_beat(ACT_REMOVE, VAL_MIN);
    for (k = ACT_CLEAR + 1; k < 2 ** ACT_W; k++)
      send_beat(ACT_W'(k), $urandom);
    send_beat(ACT_CLEAR, VAL_MAX);
    send_beat(ACT_CONTAINS, VAL_MAX);
  endtask

  task automatic run_random(input int n);
    int                      j;
    int                      pick;
    logic        [ACT_W-1:0] act;
    logic signed [VAL_W-1:0] val;
    for (j = 0; j < n; j++) begin
      // inserts outweigh removes so the list climbs to full between clears
      pick = $urandom_range(99);
      if (pick < 30)      act = ACT_APPEND;
      else if (pick < 50) act = ACT_PREPEND;
      else if (pick < 75) act = ACT_REMOVE;
      else if (pick < 94) act = ACT_CONTAINS;
      else if (pick < 96) act = ACT_CLEAR;
      else                act = ACT_W'($urandom_range(2 ** ACT_W - 1, ACT_CLEAR + 1));
      pick = $urandom_range(7);
      if (pick < 4 && mirror.held > 0) val = mirror.pick_held();
      else if (pick < 6)               val = VAL_W'($urandom_range(8)) - 32'sd4;
      else if (pick == 6)              val = $urandom_range(1) ? VAL_MIN : VAL_MAX;
      else                             val = $urandom;
      send_beat(act, val);
      if ($urandom_range(79) == 0) drain_replies();
    end
  endtask

  initial begin
    mirror = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 49;
    run_directed();
    run_random(RANDOM_PER_PHASE);
    drain_replies();

    send_idle_pct = 49;
    recv_idle_pct = 35;
    run_random(RANDOM_PER_PHASE);
    drain_replies();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);
    drain_replies();

    // catch any stray reply after the last one
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d list operations over three idling phases, %0d replies checked",
             beats_sent, mirror.replies_seen);
    $display("Inserts refused on a full list %0d, removes with no match %0d, lookup hits %0d",
             mirror.full_refusals, mirror.failed_removes, mirror.lookup_hits);
    if (mirror.errors == 0 && mirror.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
src/olv_pkg.sv
src/olv_ctrl.sv
src/olv_dp.sv
src/ordered_value_list_unit.sv
src/olv_checker.sv
tb/sv/olv_list_mirror_pkg.sv
tb/sv/tb_ordered_value_list_unit.sv
